// ===== rtl/adc_scan_sequencer_supersample_top_defines.svh =====
// Assertion macros for the ADC scan sequencer.
// Included by modules that check their own logic; no other dependencies.
`ifndef ADC_SCAN_SEQUENCER_SUPERSAMPLE_TOP_DEFINES_SVH
`define ADC_SCAN_SEQUENCER_SUPERSAMPLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ADCSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ADCSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ADCSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ADCSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/adcss_pkg.sv =====
// Shared types and constants for the ADC scan sequencer.
// No dependencies.
`default_nettype none
package adcss_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int MAX_SAMPLES = 64;
	localparam int CNT_W = 7;
	localparam int SUM_W = 16;
	localparam int VAL_W = 10;
	localparam int CH_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 7;

	// channel codes
	localparam logic [CH_W-1:0] CH_CURRENT = 3'd0;
	localparam logic [CH_W-1:0] CH_BATTERY = 3'd1;
	localparam logic [CH_W-1:0] CH_POSITION = 3'd2;
	localparam logic [CH_W-1:0] CH_TEMPERATURE = 3'd3;
	localparam logic [CH_W-1:0] CH_BACKEMF = 3'd7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUM_SHIFT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_BITS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_EN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BATT_EN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BEMF_EN = 3'd5;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_POSITION = 3'd1,
		KIND_CURRENT = 3'd2,
		KIND_TEMPERATURE = 3'd3,
		KIND_BATTERY = 3'd4,
		KIND_BACKEMF = 3'd5
	} kind_t;

	typedef struct packed {
		logic start;
		logic [CH_W-1:0] next;
		kind_t kind;
		logic [VAL_W-1:0] val;
		logic [SUM_W-1:0] fine;
	} result_t;

	function automatic logic [VAL_W-1:0] sat10(input logic [SUM_W:0] v);
		logic [VAL_W-1:0] r;
		r = (v > (SUM_W+1)'(10'h3FF)) ? 10'h3FF : v[VAL_W-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/adc_scan_sequencer_supersample_top.sv =====
// ADC scan sequencer: one input item per clock unless the result side stalls,
// one result item per input item, passed through the input register, then the
// result register. Between them lie the saturating accumulate, rounding shift and
// coarse shift; the input register can still take one item while a result waits.
// Uses adcss_pkg and adc_scan_sequencer_supersample_top_defines.svh.
`default_nettype none
`include "adc_scan_sequencer_supersample_top_defines.svh"
module adc_scan_sequencer_supersample_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [adcss_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [adcss_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic mode,
	input wire logic [adcss_pkg::CH_W-1:0] start_channel,
	input wire logic [adcss_pkg::VAL_W-1:0] sample,
	output logic out_valid,
	input wire logic out_ready,
	output logic start_conversion,
	output logic [adcss_pkg::CH_W-1:0] conv_channel,
	output logic [2:0] update_kind,
	output logic [adcss_pkg::VAL_W-1:0] value,
	output logic [adcss_pkg::SUM_W-1:0] fine_value
);

	localparam int CW = adcss_pkg::CNT_W;
	localparam int SW = adcss_pkg::SUM_W;
	localparam int HW = adcss_pkg::CH_W;

	// configuration
	logic [CW-1:0] sample_count_q;
	logic [2:0] sum_shift_q;
	logic [2:0] extra_bits_q;
	logic temp_en_q, batt_en_q, bemf_en_q;

	// state
	logic [HW-1:0] active_q;
	logic [CW-1:0] left_q;
	logic [SW-1:0] sum_q;

	// input stage
	logic valid_s1;
	logic mode_s1;
	logic [HW-1:0] chan_s1;
	logic [adcss_pkg::VAL_W-1:0] smp_s1;

	// result register
	logic out_valid_q;
	adcss_pkg::result_t res_q;
	adcss_pkg::result_t res_d;

	logic out_free, adv;
	logic [CW-1:0] left_d;
	logic [SW-1:0] sum_d;
	logic [SW-1:0] sum_acc;
	logic [CW-1:0] left_dec;
	logic [SW:0] sum_wide, rnd, fine_w, coarse_w;
	logic [adcss_pkg::VAL_W-1:0] smp_m;
	logic [CW-1:0] load_cnt;

	assign out_free = !out_valid_q || out_ready;
	assign adv = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= CW'(16);
			sum_shift_q <= 3'd2;
			extra_bits_q <= 3'd2;
			temp_en_q <= 1'b1;
			batt_en_q <= 1'b1;
			bemf_en_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				adcss_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_wdata[CW-1:0];
				adcss_pkg::CFG_SUM_SHIFT: sum_shift_q <= cfg_wdata[2:0];
				adcss_pkg::CFG_EXTRA_BITS: extra_bits_q <= cfg_wdata[2:0];
				adcss_pkg::CFG_TEMP_EN: temp_en_q <= cfg_wdata[0];
				adcss_pkg::CFG_BATT_EN: batt_en_q <= cfg_wdata[0];
				adcss_pkg::CFG_BEMF_EN: bemf_en_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= mode;
			chan_s1 <= start_channel;
			smp_s1 <= sample;
		end
	end

	// sample masked to the converter width
	always_comb begin
		smp_m = smp_s1 & adcss_pkg::VAL_W'((1 << adcss_pkg::SAMPLE_BITS) - 1);
	end

	assign load_cnt = (sample_count_q > CW'(adcss_pkg::MAX_SAMPLES)) ?
		CW'(adcss_pkg::MAX_SAMPLES) : sample_count_q;

	// position accumulate, rounded shift, coarse shift
	assign sum_wide = {1'b0, sum_q} + (SW+1)'(smp_m);
	assign sum_acc = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
	assign left_dec = (left_q != '0) ? left_q - CW'(1) : '0;
	assign rnd = ((SW+1)'(1) << sum_shift_q) >> 1;
	assign fine_w = ({1'b0, sum_acc} + rnd) >> sum_shift_q;
	assign coarse_w = ({1'b0, (fine_w[SW] ? {SW{1'b1}} : fine_w[SW-1:0])}) >> extra_bits_q;

	always_comb begin
		res_d = '0;
		res_d.kind = adcss_pkg::KIND_NONE;
		left_d = left_q;
		sum_d = sum_q;
		if (!mode_s1) begin
			if (chan_s1 == adcss_pkg::CH_POSITION) begin
				left_d = load_cnt;
				sum_d = '0;
			end
			res_d.start = 1'b1;
			res_d.next = chan_s1;
		end else begin
			unique case (active_q)
				adcss_pkg::CH_POSITION: begin
					sum_d = sum_acc;
					left_d = left_dec;
					res_d.start = 1'b1;
					if (left_dec != '0) begin
						res_d.next = adcss_pkg::CH_POSITION;
					end else begin
						res_d.next = adcss_pkg::CH_CURRENT;
						res_d.kind = adcss_pkg::KIND_POSITION;
						res_d.fine = fine_w[SW] ? {SW{1'b1}} : fine_w[SW-1:0];
						res_d.val = adcss_pkg::sat10(coarse_w);
					end
				end
				adcss_pkg::CH_CURRENT: begin
					res_d.kind = adcss_pkg::KIND_CURRENT;
					res_d.val = adcss_pkg::sat10((SW+1)'(smp_m));
					if (temp_en_q) begin
						res_d.start = 1'b1;
						res_d.next = adcss_pkg::CH_TEMPERATURE;
					end else if (batt_en_q) begin
						res_d.start = 1'b1;
						res_d.next = adcss_pkg::CH_BATTERY;
					end
				end
				adcss_pkg::CH_TEMPERATURE: begin
					if (temp_en_q) begin
						res_d.kind = adcss_pkg::KIND_TEMPERATURE;
						res_d.val = adcss_pkg::sat10((SW+1)'(smp_m));
						if (batt_en_q) begin
							res_d.start = 1'b1;
							res_d.next = adcss_pkg::CH_BATTERY;
						end
					end
				end
				adcss_pkg::CH_BATTERY: begin
					if (batt_en_q) begin
						res_d.kind = adcss_pkg::KIND_BATTERY;
						res_d.val = adcss_pkg::sat10((SW+1)'(smp_m));
					end
				end
				adcss_pkg::CH_BACKEMF: begin
					if (bemf_en_q) begin
						res_d.kind = adcss_pkg::KIND_BACKEMF;
						res_d.val = adcss_pkg::sat10((SW+1)'(smp_m));
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= adcss_pkg::CH_POSITION;
			left_q <= '0;
			sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (adv) begin
				left_q <= left_d;
				sum_q <= sum_d;
				if (res_d.start) begin
					active_q <= res_d.next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign start_conversion = res_q.start;
	assign conv_channel = res_q.next;
	assign update_kind = res_q.kind;
	assign value = res_q.val;
	assign fine_value = res_q.fine;

	`ADCSS_ASSERT_IMP(a_left_range, clk, arst_n, 1'b1, left_q <= CW'(adcss_pkg::MAX_SAMPLES))
	`ADCSS_ASSERT_IMP(a_pos_chains_current, clk, arst_n,
		adv && res_d.kind == adcss_pkg::KIND_POSITION,
		res_d.start && res_d.next == adcss_pkg::CH_CURRENT)
	`ADCSS_ASSERT_NXT(a_start_sets_active, clk, arst_n, adv && !mode_s1,
		active_q == $past(chan_s1))
	`ADCSS_ASSERT_NXT(a_s1_holds, clk, arst_n, valid_s1 && !out_free,
		valid_s1 && $stable(chan_s1) && $stable(smp_s1))
	`ADCSS_ASSERT_IMP(a_idle_result_clean, clk, arst_n, out_valid_q && !res_q.start,
		res_q.next == '0)

endmodule
`default_nettype wire
